// ===== rtl/afd_pkg.sv =====
// Package for the frame deframer: types, codes and the frame-type classifier.
`default_nettype none
package afd_pkg;

  localparam logic [7:0] START_BYTE    = 8'h7E;
  localparam logic [7:0] CHECK_BASE    = 8'hFF;
  localparam logic [7:0] TYPE_AT_RESP  = 8'h88;
  localparam logic [7:0] TYPE_EXT_TX   = 8'h8B;
  localparam logic [7:0] TYPE_RX_PKT   = 8'h90;
  localparam logic [7:0] TYPE_EXPL_RX  = 8'h91;

  localparam logic [2:0] CLS_AT_RESP   = 3'd0;
  localparam logic [2:0] CLS_EXT_TX    = 3'd1;
  localparam logic [2:0] CLS_RX_PKT    = 3'd2;
  localparam logic [2:0] CLS_EXPL_RX   = 3'd3;
  localparam logic [2:0] CLS_UNKNOWN   = 3'd4;

  localparam int QDEPTH = 4;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN_HI  = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CHECK   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_END_GOOD  = 2'd1,
    KIND_END_BAD   = 2'd2,
    KIND_BAD_START = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic        first_of_frame;
    logic [2:0]  frame_type_class;
    logic [15:0] frame_length;
  } res_t;

  function automatic logic [2:0] classify(input logic [7:0] t);
    logic [2:0] c;
    case (t)
      TYPE_AT_RESP: c = CLS_AT_RESP;
      TYPE_EXT_TX:  c = CLS_EXT_TX;
      TYPE_RX_PKT:  c = CLS_RX_PKT;
      TYPE_EXPL_RX: c = CLS_EXPL_RX;
      default:      c = CLS_UNKNOWN;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/afd_front.sv =====
// Front end: accepts received bytes, runs the frame parser and builds results.
`default_nettype none
module afd_front
  import afd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] rx_byte,
  output logic            push,
  output res_t            push_data
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] declared_length_r, declared_length_nxt;
  logic [15:0] bytes_seen_r, bytes_seen_nxt;
  logic [7:0]  running_sum_r, running_sum_nxt;
  logic [2:0]  type_class_r, type_class_nxt;
  logic [16:0] seen_inc;
  logic [2:0]  cls_now;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= PH_HUNT;
      declared_length_r <= '0;
      bytes_seen_r      <= '0;
      running_sum_r     <= '0;
      type_class_r      <= CLS_UNKNOWN;
    end else if (accept) begin
      phase_r           <= phase_nxt;
      declared_length_r <= declared_length_nxt;
      bytes_seen_r      <= bytes_seen_nxt;
      running_sum_r     <= running_sum_nxt;
      type_class_r      <= type_class_nxt;
    end
  end

  always_comb begin
    phase_nxt           = phase_r;
    declared_length_nxt = declared_length_r;
    bytes_seen_nxt      = bytes_seen_r;
    running_sum_nxt     = running_sum_r;
    type_class_nxt      = type_class_r;
    seen_inc            = {1'b0, bytes_seen_r} + 17'd1;
    cls_now             = (bytes_seen_r == '0) ? classify(rx_byte) : type_class_r;
    push                = 1'b0;
    push_data.kind             = KIND_PAYLOAD;
    push_data.data_byte        = rx_byte;
    push_data.first_of_frame   = 1'b0;
    push_data.frame_type_class = type_class_r;
    push_data.frame_length     = declared_length_r;
    case (phase_r)
      PH_LEN_HI: begin
        declared_length_nxt = {rx_byte, 8'h00};
        phase_nxt           = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        declared_length_nxt = {declared_length_r[15:8], rx_byte};
        phase_nxt = (declared_length_nxt == '0) ? PH_CHECK : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        type_class_nxt  = cls_now;
        running_sum_nxt = running_sum_r + rx_byte;
        bytes_seen_nxt  = seen_inc[15:0];
        push            = accept;
        push_data.first_of_frame   = (bytes_seen_r == '0);
        push_data.frame_type_class = cls_now;
        if (seen_inc >= {1'b0, declared_length_r}) begin
          phase_nxt = PH_CHECK;
        end
      end
      PH_CHECK: begin
        push           = accept;
        push_data.kind = (rx_byte == (CHECK_BASE - running_sum_r)) ?
                         KIND_END_GOOD : KIND_END_BAD;
        phase_nxt      = PH_HUNT;
      end
      default: begin
        phase_nxt = PH_HUNT;
        if (rx_byte == START_BYTE) begin
          declared_length_nxt = '0;
          bytes_seen_nxt      = '0;
          running_sum_nxt     = '0;
          type_class_nxt      = CLS_UNKNOWN;
          phase_nxt           = PH_LEN_HI;
        end else begin
          push                       = accept;
          push_data.kind             = KIND_BAD_START;
          push_data.frame_type_class = CLS_UNKNOWN;
          push_data.frame_length     = '0;
        end
      end
    endcase
  end

  a_check_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && phase_r == PH_CHECK) |=> (phase_r == PH_HUNT))
    else $error("parser did not return to hunting after checksum");

  a_count_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (bytes_seen_r < declared_length_r))
    else $error("payload count reached declared length while in payload");

endmodule
`default_nettype wire

// ===== rtl/afd_fifo.sv =====
// Short result queue between the parser and the output stage.
`default_nettype none
module afd_fifo
  import afd_pkg::*;
#(
  parameter int DEPTH = QDEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire res_t push_data,
  output logic      full,
  input  wire logic pop,
  output res_t      head,
  output logic      not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  res_t            mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r, count_nxt;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign count_nxt = count_r + CW'(push) - CW'(pop);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("result queue underflow");

endmodule
`default_nettype wire

// ===== rtl/afd_back.sv =====
// Back end: drains the result queue into the output register.
`default_nettype none
module afd_back
  import afd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic not_empty,
  input  wire res_t head,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output res_t      out_res
);

  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;

  assign pop           = not_empty && (!out_valid_r || !out_stall);
  assign out_valid_nxt = pop || (out_valid_r && out_stall);
  assign out_valid     = out_valid_r;
  assign out_res       = out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_res_r <= head;
    end
  end

  a_pop_shows: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid_r)
    else $error("popped result not presented");

endmodule
`default_nettype wire

// ===== rtl/api_frame_deframer.sv =====
// Top level of the length-prefixed frame deframer.
//
// Takes one received byte per clock cycle while in_stall is low and passes
// payload bytes, frame-end verdicts and bad-start reports out as result
// transactions. The parser builds each result combinationally from the byte
// and its registered state; each result enters a QUEUE_DEPTH-entry queue and
// then the output register, which drives out_valid. in_stall rises only while
// the queue is full; with QUEUE_DEPTH above one that happens only when the
// output side has been stalling, and with the output side free the block
// then sustains one byte per cycle. Start and length bytes produce no result.
`default_nettype none
module api_frame_deframer
  import afd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QDEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_data_byte,
  output logic             out_first_of_frame,
  output logic [2:0]       out_frame_type_class,
  output logic [15:0]      out_frame_length
);

  logic accept;
  logic push, pop, full, not_empty;
  res_t push_data, head, out_res;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  afd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .rx_byte   (in_rx_byte),
    .push      (push),
    .push_data (push_data)
  );

  afd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty)
  );

  afd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .not_empty (not_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_kind             = out_res.kind;
  assign out_data_byte        = out_res.data_byte;
  assign out_first_of_frame   = out_res.first_of_frame;
  assign out_frame_type_class = out_res.frame_type_class;
  assign out_frame_length     = out_res.frame_length;

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Testbench for api_frame_deframer: directed frames, then random frames under idling and stalls.
`timescale 1ns / 1ps
module tb;
  import afd_pkg::*;

  localparam int ITEMS = 850;
  localparam int DIR_N = 27;
  localparam int TAIL_N = 100;
  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 60;

  typedef struct {
    logic [7:0] rx;
    bit         typed;
    res_t       want;
  } stim_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_kind;
  logic [7:0]  out_data_byte;
  logic        out_first_of_frame;
  logic [2:0]  out_frame_type_class;
  logic [15:0] out_frame_length;

  api_frame_deframer dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind(out_kind),
    .out_data_byte(out_data_byte),
    .out_first_of_frame(out_first_of_frame),
    .out_frame_type_class(out_frame_type_class),
    .out_frame_length(out_frame_length)
  );

  stim_t stim[$];
  stim_t dir_tab [DIR_N];
  res_t  pending_results[$];

  // deframer state mirror
  phase_t      ps;
  logic [15:0] p_len;
  logic [15:0] p_cnt;
  logic [7:0]  p_sum;
  logic [2:0]  p_cls;

  int  errors;
  int  acc_cnt;
  int  n_payload, n_good, n_bad, n_badstart;
  bit  quiet_tail;
  bit  hold_done;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("** api_frame_deframer: FAILED **");
    $finish;
  end

  function automatic res_t mk(kind_t k, logic [7:0] d, logic f, logic [2:0] c,
                              logic [15:0] l);
    res_t r;
    r.kind = k;
    r.data_byte = d;
    r.first_of_frame = f;
    r.frame_type_class = c;
    r.frame_length = l;
    return r;
  endfunction

  function automatic logic [2:0] frame_class(logic [7:0] t);
    logic [2:0] c;
    c = CLS_UNKNOWN;
    if (t == TYPE_AT_RESP) c = CLS_AT_RESP;
    else if (t == TYPE_EXT_TX) c = CLS_EXT_TX;
    else if (t == TYPE_RX_PKT) c = CLS_RX_PKT;
    else if (t == TYPE_EXPL_RX) c = CLS_EXPL_RX;
    return c;
  endfunction

  task automatic deframe_step(input logic [7:0] b, output bit got, output res_t r);
    logic       first;
    logic [7:0] good_cs;
    kind_t      k;
    got = 1'b0;
    r = '0;
    case (ps)
      PH_LEN_HI: begin
        p_len = {b, 8'h00};
        ps = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        p_len[7:0] = b;
        ps = (p_len == 16'd0) ? PH_CHECK : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        first = (p_cnt == 16'd0);
        if (first) p_cls = frame_class(b);
        p_sum = p_sum + b;
        p_cnt = p_cnt + 16'd1;
        got = 1'b1;
        r = mk(KIND_PAYLOAD, b, first, p_cls, p_len);
        if (p_cnt >= p_len) ps = PH_CHECK;
      end
      PH_CHECK: begin
        good_cs = CHECK_BASE - p_sum;
        k = (b == good_cs) ? KIND_END_GOOD : KIND_END_BAD;
        got = 1'b1;
        r = mk(k, b, 1'b0, p_cls, p_len);
        ps = PH_HUNT;
      end
      default: begin
        if (b == START_BYTE) begin
          p_len = '0;
          p_cnt = '0;
          p_sum = '0;
          p_cls = CLS_UNKNOWN;
          ps = PH_LEN_HI;
        end else begin
          ps = PH_HUNT;
          got = 1'b1;
          r = mk(KIND_BAD_START, b, 1'b0, CLS_UNKNOWN, 16'd0);
        end
      end
    endcase
  endtask

  task automatic add_byte(input logic [7:0] b);
    stim_t s;
    s.rx = b;
    s.typed = 1'b0;
    s.want = '0;
    stim.insert(stim.size(), s);
  endtask

  // from index fill_at on, payload bytes are start bytes carried as data
  task automatic add_frame(input logic [15:0] len, input bit cs_ok, input int fill_at);
    logic [7:0] pb;
    logic [7:0] sum;
    logic [7:0] cs;
    logic [7:0] types [4];
    types = '{TYPE_AT_RESP, TYPE_EXT_TX, TYPE_RX_PKT, TYPE_EXPL_RX};
    sum = '0;
    add_byte(START_BYTE);
    add_byte(len[15:8]);
    add_byte(len[7:0]);
    for (int i = 0; i < int'(len); i++) begin
      if (i >= fill_at) pb = START_BYTE;
      else if (i == 0 && $urandom_range(0, 1) == 1) pb = types[$urandom_range(0, 3)];
      else pb = 8'($urandom);
      sum = sum + pb;
      add_byte(pb);
    end
    cs = CHECK_BASE - sum;
    if (!cs_ok) cs = cs ^ 8'($urandom_range(1, 255));
    add_byte(cs);
  endtask

  function automatic logic [15:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 16'd0;
    if (r < 97) return 16'($urandom_range(1, 12));
    return 16'($urandom_range(256, 300));
  endfunction

  function automatic void cmp(string f, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, f, want, got);
    end
  endfunction

  always @(posedge clk) begin : accept_mon
    bit   got;
    res_t r;
    if (rst_n && in_valid && !in_stall) begin
      deframe_step(in_rx_byte, got, r);
      if (stim[acc_cnt].typed) begin
        pending_results.insert(pending_results.size(), stim[acc_cnt].want);
      end else if (got) begin
        pending_results.insert(pending_results.size(), r);
      end
      acc_cnt++;
    end
  end

  always @(posedge clk) begin : result_chk
    res_t w;
    if (rst_n && out_valid && !out_stall) begin
      case (kind_t'(out_kind))
        KIND_PAYLOAD:  n_payload++;
        KIND_END_GOOD: n_good++;
        KIND_END_BAD:  n_bad++;
        default:       n_badstart++;
      endcase
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transaction kind=%0d data=0x%0h", $time,
                 out_kind, out_data_byte);
      end else begin
        w = pending_results.pop_front();
        cmp("kind", w.kind, out_kind);
        cmp("data_byte", w.data_byte, out_data_byte);
        cmp("first_of_frame", w.first_of_frame, out_first_of_frame);
        cmp("frame_type_class", w.frame_type_class, out_frame_type_class);
        cmp("frame_length", w.frame_length, out_frame_length);
      end
    end
  end

  // output side: random stall bursts, one long hold, quiet at the tail
  initial begin : sink
    int stall_pct;
    out_stall <= 1'b0;
    stall_pct = 15;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 49) == 0) stall_pct = ($urandom_range(0, 1) == 1) ? 15 : 0;
      if (!hold_done && acc_cnt >= HOLD_AT) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_done = 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : source
    int sel;
    int len;
    int idle_pct;
    in_valid <= 1'b0;
    in_rx_byte <= 8'h00;
    rst_n <= 1'b0;
    ps = PH_HUNT;
    p_len = '0;
    p_cnt = '0;
    p_sum = '0;
    p_cls = CLS_UNKNOWN;

    dir_tab = '{
      '{8'h00, 1'b1, mk(KIND_BAD_START, 8'h00, 1'b0, CLS_UNKNOWN, 16'd0)},
      '{8'hFF, 1'b1, mk(KIND_BAD_START, 8'hFF, 1'b0, CLS_UNKNOWN, 16'd0)},
      '{8'h7E, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'hFF, 1'b1, mk(KIND_END_GOOD, 8'hFF, 1'b0, CLS_UNKNOWN, 16'd0)},
      '{8'h7E, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b1, mk(KIND_END_BAD, 8'h00, 1'b0, CLS_UNKNOWN, 16'd0)},
      '{8'h7E, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h01, 1'b0, '0},
      '{8'h88, 1'b1, mk(KIND_PAYLOAD, 8'h88, 1'b1, CLS_AT_RESP, 16'd1)},
      '{8'h77, 1'b1, mk(KIND_END_GOOD, 8'h77, 1'b0, CLS_AT_RESP, 16'd1)},
      '{8'h7E, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h01, 1'b0, '0},
      '{8'h8B, 1'b1, mk(KIND_PAYLOAD, 8'h8B, 1'b1, CLS_EXT_TX, 16'd1)},
      '{8'h00, 1'b1, mk(KIND_END_BAD, 8'h00, 1'b0, CLS_EXT_TX, 16'd1)},
      '{8'h7E, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h03, 1'b0, '0},
      '{8'h90, 1'b0, '0},
      '{8'h7E, 1'b0, '0},
      '{8'h91, 1'b0, '0},
      '{8'h60, 1'b1, mk(KIND_END_GOOD, 8'h60, 1'b0, CLS_RX_PKT, 16'd3)}
    };
    foreach (dir_tab[i]) stim.insert(stim.size(), dir_tab[i]);

    while (stim.size() < ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 75) begin
        add_frame(pick_len(), $urandom_range(0, 99) < 85, 1 << 20);
      end else if (sel < 88) begin
        repeat ($urandom_range(1, 5)) begin
          logic [7:0] nb;
          nb = 8'($urandom);
          if (nb == START_BYTE) nb = ~nb;
          add_byte(nb);
        end
      end else begin
        len = $urandom_range(2, 10);
        add_frame(16'(len), $urandom_range(0, 1) == 1, $urandom_range(0, len - 1));
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    idle_pct = 20;
    for (int i = 0; i < stim.size(); i++) begin
      if (i % 50 == 0) idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 20;
      if (i >= stim.size() - TAIL_N) quiet_tail = 1'b1;
      if (!quiet_tail && $urandom_range(0, 99) < idle_pct) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_rx_byte <= stim[i].rx;
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes (directed frames, random frames, noise, start bytes in payload).",
             acc_cnt);
    $display("Results: %0d payload, %0d good ends, %0d bad-checksum ends, %0d bad starts.",
             n_payload, n_good, n_bad, n_badstart);
    if (errors == 0) begin
      $display("** api_frame_deframer: PASSED **");
    end else begin
      $display("** api_frame_deframer: FAILED **");
    end
    $finish;
  end

endmodule
